[sv/fps_pkg.sv]
// package: types, register indexes, reset values and phase codes for the fpga power sequencer
package fps_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_STABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_STABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WDT_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WDT_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOOT_SEL    = 3'd4;

	localparam logic [15:0] RST_LOW_STABLE  = 16'd150;
	localparam logic [15:0] RST_HIGH_STABLE = 16'd3;
	localparam logic [31:0] RST_WDT_TIMEOUT = 32'd3000;
	localparam logic        RST_WDT_ENABLE  = 1'b1;
	localparam logic [1:0]  RST_BOOT_SEL    = 2'd0;

	localparam logic [2:0] CODE_DOWN   = 3'd0;
	localparam logic [2:0] CODE_OFF    = 3'd1;
	localparam logic [2:0] CODE_UP     = 3'd2;
	localparam logic [2:0] CODE_READY  = 3'd3;
	localparam logic [2:0] CODE_CONFIG = 3'd4;
	localparam logic [2:0] CODE_ACTIVE = 3'd5;

	typedef enum logic [5:0] {
		PH_DOWN   = 6'b000001,
		PH_OFF    = 6'b000010,
		PH_UP     = 6'b000100,
		PH_READY  = 6'b001000,
		PH_CONFIG = 6'b010000,
		PH_ACTIVE = 6'b100000
	} phase_t;

	typedef struct packed {
		logic        activate;
		logic        rail_high;
		logic        watchdog_line;
		logic        fpga_mem_pick;
		logic [31:0] tick_now;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] fsm_state;
		logic       cfg_mem_pin;
		logic [1:0] boot_pins;
		logic       init_hold_low;
		logic       power_enable;
		logic       i2c_released;
		logic       i2c_accessible;
		logic       mem_choice;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] low_stable_ticks;
		logic [15:0] high_stable_ticks;
		logic [31:0] watchdog_timeout_ticks;
		logic        watchdog_enable;
		logic [1:0]  boot_sel;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic        mem_toggle;
		logic        low_armed;
		logic [15:0] low_start_tick;
		logic        high_armed;
		logic [15:0] high_start_tick;
		logic        kick_level;
		logic [31:0] last_kick_tick;
		logic        pin_mem;
		logic [1:0]  pin_boot;
		logic        pin_init_low;
		logic        pin_power;
		logic        pin_i2c_rel;
	} seq_state_t;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		code = CODE_DOWN;
		unique case (ph)
			PH_DOWN:   code = CODE_DOWN;
			PH_OFF:    code = CODE_OFF;
			PH_UP:     code = CODE_UP;
			PH_READY:  code = CODE_READY;
			PH_CONFIG: code = CODE_CONFIG;
			PH_ACTIVE: code = CODE_ACTIVE;
			default:   code = CODE_DOWN;
		endcase
		return code;
	endfunction

endpackage

[sv/fps_cfg_regs.sv]
// configuration register file of the fpga power sequencer
module fps_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output fps_pkg::cfg_t                    cfg
);
	import fps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_stable_ticks       <= RST_LOW_STABLE;
			cfg_q.high_stable_ticks      <= RST_HIGH_STABLE;
			cfg_q.watchdog_timeout_ticks <= RST_WDT_TIMEOUT;
			cfg_q.watchdog_enable        <= RST_WDT_ENABLE;
			cfg_q.boot_sel               <= RST_BOOT_SEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOW_STABLE:  cfg_q.low_stable_ticks       <= cfg_wdata[15:0];
				REG_HIGH_STABLE: cfg_q.high_stable_ticks      <= cfg_wdata[15:0];
				REG_WDT_TIMEOUT: cfg_q.watchdog_timeout_ticks <= cfg_wdata[31:0];
				REG_WDT_ENABLE:  cfg_q.watchdog_enable        <= cfg_wdata[0];
				REG_BOOT_SEL:    cfg_q.boot_sel               <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/fps_step.sv]
// next-state and pin logic for one control step of the fpga power sequencer
module fps_step (
	input  fps_pkg::cfg_t       cfg,
	input  fps_pkg::seq_state_t cur,
	input  fps_pkg::in_beat_t   beat,
	output fps_pkg::seq_state_t nxt,
	output fps_pkg::out_beat_t  res
);
	import fps_pkg::*;

	logic [15:0] now16;
	logic [15:0] low_elapsed;
	logic [15:0] high_elapsed;
	logic        kick_changed;
	logic [31:0] kick_elapsed;
	logic        wdt_ok;
	logic        shutdown;
	logic [2:0]  code;

	assign now16        = beat.tick_now[15:0];
	assign low_elapsed  = now16 - cur.low_start_tick;
	assign high_elapsed = now16 - cur.high_start_tick;
	assign kick_changed = cur.kick_level != beat.watchdog_line;
	assign kick_elapsed = beat.tick_now - cur.last_kick_tick;
	assign wdt_ok       = !cfg.watchdog_enable || kick_changed ||
		(kick_elapsed <= cfg.watchdog_timeout_ticks);
	assign shutdown     = !wdt_ok || !beat.activate;

	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			PH_DOWN: begin
				if (!beat.rail_high) begin
					if (!cur.low_armed) begin
						nxt.low_armed      = 1'b1;
						nxt.low_start_tick = now16;
					end else if (low_elapsed >= cfg.low_stable_ticks) begin
						nxt.low_armed = 1'b0;
						nxt.phase     = PH_OFF;
					end
				end
			end
			PH_OFF: begin
				if (beat.activate) begin
					nxt.pin_init_low = 1'b1;
					nxt.pin_power    = 1'b1;
					nxt.phase        = PH_UP;
				end
			end
			PH_UP: begin
				if (beat.rail_high) begin
					if (!cur.high_armed) begin
						nxt.high_armed      = 1'b1;
						nxt.high_start_tick = now16;
					end else if (high_elapsed >= cfg.high_stable_ticks) begin
						nxt.high_armed = 1'b0;
						nxt.phase      = PH_READY;
					end
				end
			end
			PH_READY: begin
				if (!beat.activate) begin
					nxt.pin_mem      = 1'b0;
					nxt.pin_boot     = 2'd0;
					nxt.pin_init_low = 1'b0;
					nxt.pin_power    = 1'b0;
					nxt.phase        = PH_DOWN;
				end else begin
					nxt.pin_mem        = cur.mem_toggle;
					nxt.pin_boot       = cfg.boot_sel;
					nxt.pin_init_low   = 1'b0;
					nxt.pin_i2c_rel    = 1'b1;
					nxt.phase          = PH_CONFIG;
					nxt.kick_level     = 1'b0;
					nxt.last_kick_tick = beat.tick_now;
				end
			end
			PH_CONFIG, PH_ACTIVE: begin
				// watchdog restart on a line toggle
				if (cfg.watchdog_enable && kick_changed) begin
					nxt.kick_level     = beat.watchdog_line;
					nxt.last_kick_tick = beat.tick_now;
				end
				if (shutdown) begin
					nxt.mem_toggle   = !cur.mem_toggle;
					nxt.pin_mem      = 1'b0;
					nxt.pin_boot     = 2'd0;
					nxt.pin_init_low = 1'b0;
					nxt.pin_power    = 1'b0;
					nxt.phase        = PH_DOWN;
				end else if (cur.phase == PH_CONFIG) begin
					if (beat.watchdog_line) begin
						nxt.phase = PH_ACTIVE;
					end
				end else begin
					nxt.pin_mem = beat.fpga_mem_pick;
				end
			end
			default: begin
				nxt.pin_mem      = 1'b0;
				nxt.pin_boot     = 2'd0;
				nxt.pin_init_low = 1'b0;
				nxt.pin_power    = 1'b0;
				nxt.phase        = PH_DOWN;
			end
		endcase
	end

	assign code = phase_code(nxt.phase);

	always_comb begin
		res.fsm_state      = code;
		res.cfg_mem_pin    = nxt.pin_mem;
		res.boot_pins      = nxt.pin_boot;
		res.init_hold_low  = nxt.pin_init_low;
		res.power_enable   = nxt.pin_power;
		res.i2c_released   = nxt.pin_i2c_rel;
		res.i2c_accessible = (code == CODE_OFF) || (code == CODE_READY);
		res.mem_choice     = nxt.mem_toggle;
	end

endmodule

[sv/fpga_power_sequencer_core.sv]
// top level of the fpga power sequencer: input stage, step logic, result register
//
// channel  | signals                       | direction
// ---------+-------------------------------+----------
// in       | in_valid, in_ready, in_data   | sink
// out      | out_valid, out_ready, out_data| source
// cfg      | cfg_we, cfg_index, cfg_wdata  | sink, write only
//
// one beat per cycle while the output is not stalled; a taken beat's result becomes valid
// when it moves from the input register, through step logic, into the result register
// sequencer state updates when a beat moves from the input to the result register
// a stalled output holds both registers; the input still takes a beat while its register is free
// reset clears the control state and loads the register reset values
module fpga_power_sequencer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  fps_pkg::in_beat_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output fps_pkg::out_beat_t             out_data,
	input  logic                           cfg_we,
	input  logic [fps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fps_pkg::*;

	cfg_t       cfg;
	seq_state_t state_q;
	seq_state_t state_nxt;
	in_beat_t   in_s1;
	logic       in_valid_s1;
	out_beat_t  res;
	out_beat_t  out_s2;
	logic       out_valid_s2;
	logic       advance;

	fps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fps_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.beat (in_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	assign advance  = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= PH_DOWN;
			state_q.mem_toggle      <= 1'b0;
			state_q.low_armed       <= 1'b0;
			state_q.low_start_tick  <= 16'd0;
			state_q.high_armed      <= 1'b0;
			state_q.high_start_tick <= 16'd0;
			state_q.kick_level      <= 1'b0;
			state_q.last_kick_tick  <= 32'd0;
			state_q.pin_mem         <= 1'b0;
			state_q.pin_boot        <= 2'd0;
			state_q.pin_init_low    <= 1'b0;
			state_q.pin_power       <= 1'b0;
			state_q.pin_i2c_rel     <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_s2;

`ifndef ASSERT_OFF
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_s2)
		else $error("beat moved on but no result was held");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !advance |=> in_valid_s1 && $stable(in_s1))
		else $error("input stage lost a stalled beat");

	a_run_powered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && (out_s2.fsm_state == CODE_CONFIG || out_s2.fsm_state == CODE_ACTIVE)
		|-> out_s2.power_enable && !out_s2.init_hold_low)
		else $error("config or active without power or with init held low");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("sequencer state changed without a beat");
`endif

endmodule

[bench/fpga_power_sequencer_core_tb.sv]
// testbench for fpga_power_sequencer_core: directed table then randomized drills, checked beat by beat
`timescale 1ns / 100ps

module fpga_power_sequencer_core_tb;
	import fps_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		logic [CFG_IDX_W-1:0]      reg_idx;
		logic [CFG_DATA_W-1:0]     wdata;
		in_beat_t                  stim;
		bit                        typed;
		out_beat_t                 want;
	} row_t;

	typedef struct {
		cfg_t regs;
		int   stride;
		int   jump_pct;
		int   wild_pct;
	} drill_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_beat_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_beat_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	cfg_t        knobs = '{RST_LOW_STABLE, RST_HIGH_STABLE, RST_WDT_TIMEOUT, RST_WDT_ENABLE,
		RST_BOOT_SEL};
	logic [2:0]  seq_phase = CODE_DOWN;
	logic        mem_flip = 1'b0;
	logic        low_seen = 1'b0;
	logic [15:0] low_since = '0;
	logic        high_seen = 1'b0;
	logic [15:0] high_since = '0;
	logic        wd_line_seen = 1'b0;
	logic [31:0] wd_mark = '0;
	logic        pin_mem = 1'b0;
	logic [1:0]  pin_boot = '0;
	logic        pin_init = 1'b0;
	logic        pin_power = 1'b0;
	logic        pin_rel = 1'b0;

	out_beat_t   pending_outputs[$];
	int          faults = 0;
	bit          feed_calm = 1'b0;
	bit          drain_calm = 1'b0;
	logic [31:0] tick_run = '0;
	logic        line_run = 1'b0;

	fpga_power_sequencer_core dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.cfg_we,
		.cfg_index,
		.cfg_wdata
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("fpga_power_sequencer_core regression: fail");
		$finish;
	end

	function automatic void pins_off();
		pin_mem = 1'b0;
		pin_boot = 2'd0;
		pin_init = 1'b0;
		pin_power = 1'b0;
		seq_phase = CODE_DOWN;
	endfunction

	function automatic out_beat_t advance_sequencer(in_beat_t b);
		logic [15:0] now16;
		logic [15:0] held;
		logic        alive;
		now16 = b.tick_now[15:0];
		alive = 1'b1;
		case (seq_phase)
		CODE_DOWN: if (!b.rail_high) begin
			held = now16 - low_since;
			if (!low_seen) begin
				low_seen = 1'b1;
				low_since = now16;
			end else if (held >= knobs.low_stable_ticks) begin
				low_seen = 1'b0;
				seq_phase = CODE_OFF;
			end
		end
		CODE_OFF: if (b.activate) begin
			pin_init = 1'b1;
			pin_power = 1'b1;
			seq_phase = CODE_UP;
		end
		CODE_UP: if (b.rail_high) begin
			held = now16 - high_since;
			if (!high_seen) begin
				high_seen = 1'b1;
				high_since = now16;
			end else if (held >= knobs.high_stable_ticks) begin
				high_seen = 1'b0;
				seq_phase = CODE_READY;
			end
		end
		CODE_READY: if (!b.activate) begin
			pins_off();
		end else begin
			pin_mem = mem_flip;
			pin_boot = knobs.boot_sel;
			pin_init = 1'b0;
			pin_rel = 1'b1;
			seq_phase = CODE_CONFIG;
			wd_line_seen = 1'b0;
			wd_mark = b.tick_now;
		end
		CODE_CONFIG, CODE_ACTIVE: begin
			if (knobs.watchdog_enable) begin
				if (wd_line_seen != b.watchdog_line) begin
					wd_line_seen = b.watchdog_line;
					wd_mark = b.tick_now;
				end
				alive = (b.tick_now - wd_mark) <= knobs.watchdog_timeout_ticks;
			end
			if (!alive || !b.activate) begin
				mem_flip = !mem_flip;
				pins_off();
			end else if (seq_phase == CODE_CONFIG) begin
				if (b.watchdog_line)
					seq_phase = CODE_ACTIVE;
			end else begin
				pin_mem = b.fpga_mem_pick;
			end
		end
		default: pins_off();
		endcase
		return {seq_phase, pin_mem, pin_boot, pin_init, pin_power, pin_rel,
			(seq_phase == CODE_OFF || seq_phase == CODE_READY), mem_flip};
	endfunction

	function automatic int pause_len(inout bit calm);
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic row_t beat_row(logic [3:0] bits, logic [31:0] t, bit typed = 1'b0,
			out_beat_t want = '0);
		row_t r;
		r.kind = ROW_BEAT;
		r.reg_idx = '0;
		r.wdata = '0;
		{r.stim.activate, r.stim.rail_high, r.stim.watchdog_line, r.stim.fpga_mem_pick} = bits;
		r.stim.tick_now = t;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		row_t r;
		r = beat_row(4'b0000, '0);
		r.kind = ROW_WRITE;
		r.reg_idx = idx;
		r.wdata = value;
		return r;
	endfunction

	function automatic in_beat_t draw_step(drill_t d);
		in_beat_t b;
		int       roll;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			{b.activate, b.rail_high, b.watchdog_line, b.fpga_mem_pick} = 4'($urandom);
			b.tick_now = $urandom;
			return b;
		end
		roll = $urandom_range(0, 99);
		if (roll < d.jump_pct)
			tick_run += 32'h0000_FFFF;
		else if (roll < d.jump_pct + d.wild_pct)
			tick_run += $urandom;
		else
			tick_run += 32'($urandom_range(0, d.stride));
		if ($urandom_range(0, 99) < 60)
			line_run = !line_run;
		b.activate = ($urandom_range(0, 99) < 94);
		b.rail_high = ($urandom_range(0, 99) < 88) ? pin_power : !pin_power;
		b.watchdog_line = line_run;
		b.fpga_mem_pick = 1'($urandom);
		b.tick_now = tick_run;
		return b;
	endfunction

	// hold each beat until taken
	task automatic push_step(in_beat_t b, bit typed, out_beat_t want);
		int        gap;
		out_beat_t guess;
		gap = pause_len(feed_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		guess = advance_sequencer(b);
		pending_outputs.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
		REG_LOW_STABLE:  knobs.low_stable_ticks = value[15:0];
		REG_HIGH_STABLE: knobs.high_stable_ticks = value[15:0];
		REG_WDT_TIMEOUT: knobs.watchdog_timeout_ticks = value;
		REG_WDT_ENABLE:  knobs.watchdog_enable = value[0];
		REG_BOOT_SEL:    knobs.boot_sel = value[1:0];
		default: ;
		endcase
	endtask

	task automatic note(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			faults++;
		end
	endtask

	initial begin : sink
		out_beat_t got;
		out_beat_t want;
		int        gap;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = pause_len(drain_calm);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = out_data;
			if (pending_outputs.size() == 0) begin
				$error("unexpected beat: fsm_state %0d", got.fsm_state);
				faults++;
			end else begin
				want = pending_outputs.pop_front();
				note("fsm_state", 32'(want.fsm_state), 32'(got.fsm_state));
				note("cfg_mem_pin", 32'(want.cfg_mem_pin), 32'(got.cfg_mem_pin));
				note("boot_pins", 32'(want.boot_pins), 32'(got.boot_pins));
				note("init_hold_low", 32'(want.init_hold_low), 32'(got.init_hold_low));
				note("power_enable", 32'(want.power_enable), 32'(got.power_enable));
				note("i2c_released", 32'(want.i2c_released), 32'(got.i2c_released));
				note("i2c_accessible", 32'(want.i2c_accessible), 32'(got.i2c_accessible));
				note("mem_choice", 32'(want.mem_choice), 32'(got.mem_choice));
			end
		end
	end

	initial begin : stimulus
		row_t      script[$];
		drill_t    drills[6];
		out_beat_t at_rest;
		out_beat_t off_idle;
		out_beat_t tripped;

		at_rest = '0;
		at_rest.fsm_state = CODE_DOWN;
		off_idle = at_rest;
		off_idle.fsm_state = CODE_OFF;
		off_idle.i2c_accessible = 1'b1;
		tripped = at_rest;
		tripped.i2c_released = 1'b1;
		tripped.mem_choice = 1'b1;

		script.push_back(beat_row(4'b0000, 32'd0, 1'b1, at_rest));
		script.push_back(beat_row(4'b0000, 32'd149));
		script.push_back(beat_row(4'b0100, 32'd200));
		script.push_back(beat_row(4'b0000, 32'd150, 1'b1, off_idle));
		script.push_back(beat_row(4'b1000, 32'd152));
		script.push_back(beat_row(4'b1100, 32'hFFFF_FFFE));
		script.push_back(beat_row(4'b1100, 32'd0));
		script.push_back(beat_row(4'b1100, 32'd1));
		script.push_back(beat_row(4'b1110, 32'hFFFF_FFFF));
		script.push_back(beat_row(4'b1110, 32'd200));
		script.push_back(beat_row(4'b1111, 32'd3200));
		script.push_back(beat_row(4'b1110, 32'd3201, 1'b1, tripped));
		script.push_back(write_row(REG_LOW_STABLE, 32'hABCD_0000));
		script.push_back(write_row(REG_HIGH_STABLE, 32'h1234_0001));
		script.push_back(write_row(REG_WDT_ENABLE, 32'hFFFF_FFFE));
		script.push_back(write_row(REG_BOOT_SEL, 32'hFFFF_FFFF));
		script.push_back(write_row(REG_UNUSED, 32'h5A5A_A5A5));
		script.push_back(beat_row(4'b0000, 32'd5000));
		script.push_back(beat_row(4'b0000, 32'd5000));
		script.push_back(beat_row(4'b1000, 32'd5001));
		script.push_back(beat_row(4'b1100, 32'd7));
		script.push_back(beat_row(4'b1100, 32'd8));
		script.push_back(beat_row(4'b1100, 32'd10));
		script.push_back(beat_row(4'b1100, 32'h8000_0000));
		script.push_back(beat_row(4'b1110, 32'h8000_0001));
		script.push_back(beat_row(4'b1101, 32'h8000_0002));
		script.push_back(beat_row(4'b0100, 32'h8000_0003));

		drills[0] = '{'{16'd2, 16'd1, 32'd12, 1'b1, 2'd1}, 3, 4, 3};
		drills[1] = '{'{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 2'd3}, 1, 30, 0};
		drills[2] = '{'{16'd1, 16'd1, 32'd1, 1'b1, 2'd2}, 1, 4, 3};
		drills[3] = '{'{16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
			32'($urandom_range(3, 40)), 1'b0, 2'($urandom)}, 4, 4, 3};
		drills[4] = '{'{16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)),
			32'($urandom_range(1, 30)), 1'($urandom), 2'($urandom)}, 5, 5, 3};
		drills[5] = '{'{RST_LOW_STABLE, RST_HIGH_STABLE, RST_WDT_TIMEOUT, RST_WDT_ENABLE,
			RST_BOOT_SEL}, 40, 4, 3};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				drain();
				write_reg(script[i].reg_idx, script[i].wdata);
			end else begin
				push_step(script[i].stim, script[i].typed, script[i].want);
			end
		end

		foreach (drills[d]) begin
			drain();
			write_reg(REG_LOW_STABLE, 32'(drills[d].regs.low_stable_ticks));
			write_reg(REG_HIGH_STABLE, 32'(drills[d].regs.high_stable_ticks));
			write_reg(REG_WDT_TIMEOUT, drills[d].regs.watchdog_timeout_ticks);
			write_reg(REG_WDT_ENABLE, 32'(drills[d].regs.watchdog_enable));
			write_reg(REG_BOOT_SEL, 32'(drills[d].regs.boot_sel));
			repeat (250)
				push_step(draw_step(drills[d]), 1'b0, '0);
		end

		drain();
		if (faults == 0)
			$display("fpga_power_sequencer_core regression: pass");
		else
			$display("fpga_power_sequencer_core regression: fail");
		$finish;
	end

endmodule
